// File: rtl/big_block_reuse_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the big block reuse table
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BIG_BLOCK_REUSE_TABLE_ASSERT_SVH
`define BIG_BLOCK_REUSE_TABLE_ASSERT_SVH
`ifndef SYNTH
`define BBRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define BBRT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define BBRT_ASSERT(label, clk, rst_n, prop)
`define BBRT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/bbrt_pkg.sv
// ----------------------------------------------------------------------------
// Big block reuse table package
// Field widths, request and register codes, and the stored entry layout.
// ----------------------------------------------------------------------------
package bbrt_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 25;
    localparam int ALIGN_W = 5;
    localparam int SHIFT_W = 3;
    localparam int TYPE_W  = 2;
    localparam int TOTAL_W = 32;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] MIN_BLOCK_RESET = SIZE_W'(32 * 1024);
    localparam logic [SHIFT_W-1:0] WASTE_SHIFT_RESET = SHIFT_W'(3);

    localparam logic [TYPE_W-1:0] REQ_KEEP = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_TAKE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_GIVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WASTE_SHIFT = 2'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } entry_t;

endpackage

// File: rtl/big_block_reuse_table.sv
// ----------------------------------------------------------------------------
// Big block reuse table
// Keeps freed large blocks and serves best-fit takes and biggest give-backs.
// ----------------------------------------------------------------------------
// A keep word's result is valid in the cycle after acceptance. A take or a
// give-back walks the stored entries through the single read port of the
// entry memory, one entry per cycle; if an entry is picked, the last entry is
// then read once more and written into the freed slot. A new word is accepted
// only after the result has been taken. No clearing pass follows reset.
`include "big_block_reuse_table_assert.svh"

module big_block_reuse_table #(
    parameter int MAX_ENTRIES = 96
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // block_addr[31:0], block_size[56:32], request_size[81:57],
    // align_log2[86:82], zero fill above.
    input  logic [87:0] s_tdata,
    // req_type[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_addr[31:0], out_size[56:32], total_bytes[88:57], entry_count[95:89].
    output logic [95:0] m_tdata,
    // status[0].
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SW = bbrt_pkg::SIZE_W;
    localparam int AW = bbrt_pkg::ADDR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [bbrt_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [SW-1:0] min_reg;
    logic [bbrt_pkg::SHIFT_W-1:0] shift_reg;
    logic is_take_reg, is_take_next;
    logic [SW-1:0] rsize_reg, rsize_next;
    logic [SW:0] limit_reg, limit_next;
    logic [AW-1:0] amask_reg, amask_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;
    logic found_reg, found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [AW-1:0] best_addr_reg, best_addr_next;
    logic [SW-1:0] best_size_reg, best_size_next;
    logic status_reg, status_next;
    logic [AW-1:0] oaddr_reg, oaddr_next;
    logic [SW-1:0] osize_reg, osize_next;

    logic [AW-1:0] in_addr;
    logic [SW-1:0] in_bsize;
    logic [SW-1:0] in_rsize;
    logic [bbrt_pkg::ALIGN_W-1:0] in_align;
    logic [bbrt_pkg::TYPE_W-1:0] in_type;

    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    bbrt_pkg::entry_t wr_data;
    bbrt_pkg::entry_t rd_data;

    logic issue;
    logic [SW-1:0] cmp_a;
    logic [SW-1:0] cmp_b;
    logic cmp_lt;
    logic fits;
    logic better;

    assign in_addr  = s_tdata[31:0];
    assign in_bsize = s_tdata[56:32];
    assign in_rsize = s_tdata[81:57];
    assign in_align = s_tdata[86:82];
    assign in_type  = s_tuser;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;
    assign m_tuser   = status_reg;
    assign m_tdata   = {7'(count_reg), total_reg, osize_reg, oaddr_reg};

    bbrt_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared size comparator: a take looks for a smaller fit, a give-back for
    // a larger block, so the operands swap with the request kind.
    assign cmp_a  = is_take_reg ? rd_data.size : best_size_reg;
    assign cmp_b  = is_take_reg ? best_size_reg : rd_data.size;
    assign cmp_lt = cmp_a < cmp_b;
    assign fits   = (rd_data.size >= rsize_reg) && ({1'b0, rd_data.size} <= limit_reg) &&
                    ((rd_data.addr & amask_reg) == '0);
    assign better = is_take_reg ? (fits && (!found_reg || cmp_lt)) : (!found_reg || cmp_lt);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        is_take_next    = is_take_reg;
        rsize_next      = rsize_reg;
        limit_next      = limit_reg;
        amask_next      = amask_reg;
        scan_idx_next   = scan_idx_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_addr_next  = best_addr_reg;
        best_size_next  = best_size_reg;
        status_next     = status_reg;
        oaddr_next      = oaddr_reg;
        osize_next      = osize_reg;
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_data         = rd_data;
        rd_addr         = scan_idx_reg[IDX_W-1:0];
        issue           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    is_take_next    = (in_type == bbrt_pkg::REQ_TAKE);
                    rsize_next      = in_rsize;
                    limit_next      = {1'b0, in_rsize} + (SW + 1)'(in_rsize >> shift_reg);
                    amask_next      = ~({AW{1'b1}} << in_align);
                    scan_idx_next   = '0;
                    eval_valid_next = 1'b0;
                    found_next      = 1'b0;
                    status_next     = 1'b1;
                    oaddr_next      = '0;
                    osize_next      = '0;
                    state_next      = ST_OUT;
                    case (in_type)
                        bbrt_pkg::REQ_KEEP: begin
                            if (in_bsize >= min_reg && count_reg < CNT_W'(MAX_ENTRIES)) begin
                                wr_en       = 1'b1;
                                wr_addr     = count_reg[IDX_W-1:0];
                                wr_data     = '{addr: in_addr, size: in_bsize};
                                count_next  = CNT_W'(count_reg + 1'b1);
                                total_next  = total_reg + bbrt_pkg::TOTAL_W'(in_bsize);
                                status_next = 1'b0;
                            end
                        end
                        bbrt_pkg::REQ_TAKE: begin
                            if (in_rsize >= min_reg && count_reg != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        bbrt_pkg::REQ_GIVE: begin
                            if (count_reg != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                issue           = scan_idx_reg < count_reg;
                eval_valid_next = issue;
                eval_idx_next   = scan_idx_reg[IDX_W-1:0];
                if (issue) begin
                    scan_idx_next = CNT_W'(scan_idx_reg + 1'b1);
                end
                if (eval_valid_reg && better) begin
                    found_next     = 1'b1;
                    best_idx_next  = eval_idx_reg;
                    best_addr_next = rd_data.addr;
                    best_size_next = rd_data.size;
                end
                if (!issue && !eval_valid_reg) begin
                    state_next = found_reg ? ST_MOVE_RD : ST_OUT;
                end
            end
            ST_MOVE_RD: begin
                rd_addr    = IDX_W'(CNT_W'(count_reg - 1'b1));
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                wr_en       = 1'b1;
                wr_addr     = best_idx_reg;
                wr_data     = rd_data;
                count_next  = CNT_W'(count_reg - 1'b1);
                total_next  = total_reg - bbrt_pkg::TOTAL_W'(best_size_reg);
                status_next = 1'b0;
                oaddr_next  = best_addr_reg;
                osize_next  = best_size_reg;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            min_reg        <= bbrt_pkg::MIN_BLOCK_RESET;
            shift_reg      <= bbrt_pkg::WASTE_SHIFT_RESET;
            eval_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            eval_valid_reg <= eval_valid_next;
            found_reg      <= found_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bbrt_pkg::CFG_MIN_BLOCK: begin
                        min_reg <= cfg_data;
                    end
                    bbrt_pkg::CFG_WASTE_SHIFT: begin
                        shift_reg <= cfg_data[bbrt_pkg::SHIFT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        is_take_reg   <= is_take_next;
        rsize_reg     <= rsize_next;
        limit_reg     <= limit_next;
        amask_reg     <= amask_next;
        scan_idx_reg  <= scan_idx_next;
        eval_idx_reg  <= eval_idx_next;
        best_idx_reg  <= best_idx_next;
        best_addr_reg <= best_addr_next;
        best_size_reg <= best_size_next;
        status_reg    <= status_next;
        oaddr_reg     <= oaddr_next;
        osize_reg     <= osize_next;
    end

    `BBRT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_ENTRIES))
    `BBRT_ASSERT(a_one_side, aclk, aresetn, !(s_tready && m_tvalid))
    `BBRT_ASSERT(a_scan_keeps_count, aclk, aresetn, (state_reg == ST_SCAN) |=> $stable(count_reg))
    `BBRT_ASSERT(a_move_has_pick, aclk, aresetn, (state_reg == ST_MOVE_WR) |-> found_reg)
    `BBRT_ASSERT(a_fail_is_zero, aclk, aresetn, (m_tvalid && status_reg) |-> (oaddr_reg == '0 && osize_reg == '0))

endmodule

// File: rtl/bbrt_entry_ram.sv
// ----------------------------------------------------------------------------
// Entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbrt_entry_ram #(
    parameter int DEPTH = 96,
    parameter int IDX_W = 7
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  bbrt_pkg::entry_t     wr_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output bbrt_pkg::entry_t     rd_data
);

    bbrt_pkg::entry_t mem [DEPTH];
    bbrt_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: verif/big_block_reuse_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Big block reuse table checker
// Watches the request, result and register channels, keeps its own copy of
// the block table and settings, predicts the result word of every accepted
// request and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module big_block_reuse_table_checker
    import bbrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 96
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [87:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [95:0]          m_tdata,
    input  logic [0:0]           m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending_words,
    output int                   words_done,
    output int                   words_refused
);

    typedef struct packed {
        logic [TYPE_W-1:0]  kind;
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  block_bytes;
        logic [SIZE_W-1:0]  want_bytes;
        logic [ALIGN_W-1:0] align_log2;
    } alloc_req_t;

    typedef struct packed {
        logic               status;
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } alloc_rsp_t;

    logic [ADDR_W-1:0]  kept_addr [TABLE_DEPTH];
    logic [SIZE_W-1:0]  kept_size [TABLE_DEPTH];
    int                 kept_count = 0;
    logic [TOTAL_W-1:0] kept_total = '0;
    logic [SIZE_W-1:0]  min_bytes = MIN_BLOCK_RESET;
    logic [SHIFT_W-1:0] waste_shift = WASTE_SHIFT_RESET;
    alloc_rsp_t         expected_rsp_q [$];
    int                 mismatches = 0;
    int                 done_count = 0;
    int                 refused_count = 0;

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: result word mismatch in %s: expected 0x%h, got 0x%h",
                 $realtime, field, want, got);
        mismatches++;
    endtask

    function automatic alloc_rsp_t predict_alloc_step(alloc_req_t req);
        alloc_rsp_t         rsp;
        logic [TOTAL_W-1:0] fit_limit;
        logic [ADDR_W-1:0]  align_mask;
        int                 pick;
        rsp = '0;
        rsp.status = 1'b1;
        pick = -1;
        fit_limit = TOTAL_W'(req.want_bytes) + TOTAL_W'(req.want_bytes >> waste_shift);
        align_mask = (ADDR_W'(1) << req.align_log2) - ADDR_W'(1);
        case (req.kind)
            REQ_KEEP: begin
                if (req.block_bytes >= min_bytes && kept_count < TABLE_DEPTH) begin
                    kept_addr[kept_count] = req.addr;
                    kept_size[kept_count] = req.block_bytes;
                    kept_count++;
                    kept_total += TOTAL_W'(req.block_bytes);
                    rsp.status = 1'b0;
                end
            end
            REQ_TAKE: begin
                if (req.want_bytes >= min_bytes) begin
                    for (int i = 0; i < kept_count; i++) begin
                        if (kept_size[i] >= req.want_bytes
                            && TOTAL_W'(kept_size[i]) <= fit_limit
                            && (kept_addr[i] & align_mask) == '0
                            && (pick < 0 || kept_size[i] < kept_size[pick]))
                            pick = i;
                    end
                end
            end
            REQ_GIVE: begin
                if (kept_count > 0) begin
                    pick = 0;
                    for (int i = 1; i < kept_count; i++) begin
                        if (kept_size[i] > kept_size[pick])
                            pick = i;
                    end
                end
            end
            default: ;
        endcase
        // A removed entry is replaced by the last one in the table.
        if (pick >= 0) begin
            rsp.status = 1'b0;
            rsp.addr = kept_addr[pick];
            rsp.size = kept_size[pick];
            kept_total -= TOTAL_W'(kept_size[pick]);
            kept_count--;
            kept_addr[pick] = kept_addr[kept_count];
            kept_size[pick] = kept_size[kept_count];
        end
        rsp.total = kept_total;
        rsp.count = COUNT_W'(kept_count);
        return rsp;
    endfunction

    always @(posedge aclk) begin : watch
        alloc_req_t req;
        alloc_rsp_t got;
        alloc_rsp_t want;
        if (!aresetn) begin
            kept_count = 0;
            kept_total = '0;
            min_bytes = MIN_BLOCK_RESET;
            waste_shift = WASTE_SHIFT_RESET;
            expected_rsp_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser[0];
                got.addr = m_tdata[31:0];
                got.size = m_tdata[56:32];
                got.total = m_tdata[88:57];
                got.count = m_tdata[95:89];
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("unrequested word (addr)", '0, got.addr);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (want.status)
                        refused_count++;
                    else
                        done_count++;
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.addr !== want.addr)
                        report_mismatch("out_addr", want.addr, got.addr);
                    if (got.size !== want.size)
                        report_mismatch("out_size", want.size, got.size);
                    if (got.total !== want.total)
                        report_mismatch("total_bytes", want.total, got.total);
                    if (got.count !== want.count)
                        report_mismatch("entry_count", want.count, got.count);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_BLOCK:   min_bytes = cfg_data;
                    CFG_WASTE_SHIFT: waste_shift = cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                req.kind = s_tuser;
                req.addr = s_tdata[31:0];
                req.block_bytes = s_tdata[56:32];
                req.want_bytes = s_tdata[81:57];
                req.align_log2 = s_tdata[86:82];
                expected_rsp_q.push_back(predict_alloc_step(req));
            end
        end
        fail_count <= mismatches;
        pending_words <= expected_rsp_q.size();
        words_done <= done_count;
        words_refused <= refused_count;
    end

endmodule

// File: verif/tb_big_block_reuse_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Big block reuse table testbench
// Drives keep, take, give-back and unused-code request words and register writes
// into the block under several settings and idle patterns, including a long
// result stall that backs up the request channel. The checker beside the block
// predicts and compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_big_block_reuse_table;
    import bbrt_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 96;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [87:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [95:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    int fail_count;
    int pending_words;
    int words_done;
    int words_refused;

    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_asks = 0;
    int                 quiet_cycles = 0;
    int                 reg_writes = 0;
    logic [SIZE_W-1:0]  cur_min = MIN_BLOCK_RESET;
    logic [SHIFT_W-1:0] cur_shift = WASTE_SHIFT_RESET;
    logic [SIZE_W-1:0]  offered_sizes [$];

    big_block_reuse_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    big_block_reuse_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending_words(pending_words),
        .words_done(words_done),
        .words_refused(words_refused)
    );

    always #5 aclk = ~aclk;

    initial begin : receiver
        int served = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asks != served) begin
                served++;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_word(input logic [TYPE_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                             input logic [SIZE_W-1:0] bsize, input logic [SIZE_W-1:0] rsize,
                             input logic [ALIGN_W-1:0] alog);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, alog, rsize, bsize, addr};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        reg_writes++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SIZE_W-1:0] draw_size(input logic [SIZE_W-1:0] floor_bytes);
        longint pick_bytes;
        case ($urandom_range(9))
            0: return SIZE_W'($urandom());
            1: pick_bytes = floor_bytes;
            2: pick_bytes = longint'(floor_bytes) - 1;
            3: pick_bytes = SIZE_MAX;
            default: pick_bytes = longint'(floor_bytes) + $urandom_range(3 * floor_bytes + 64);
        endcase
        return (pick_bytes > SIZE_MAX) ? SIZE_MAX : SIZE_W'(pick_bytes);
    endfunction

    function automatic logic [ADDR_W-1:0] draw_addr();
        logic [ADDR_W-1:0] a;
        a = $urandom();
        case ($urandom_range(7))
            0: a = '0;
            1: a = 32'h8000_0000;
            2, 3, 4: a = a & ~((ADDR_W'(1) << $urandom_range(16)) - ADDR_W'(1));
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [ALIGN_W-1:0] draw_align();
        return ALIGN_W'(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(4));
    endfunction

    task automatic send_random_words(input int count);
        logic [SIZE_W-1:0] bsize;
        logic [SIZE_W-1:0] rsize;
        logic [SIZE_W-1:0] fit;
        int                roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                bsize = draw_size(cur_min);
                offered_sizes.push_back(bsize);
                if (offered_sizes.size() > 64)
                    void'(offered_sizes.pop_front());
                send_word(REQ_KEEP, draw_addr(), bsize, SIZE_W'($urandom()),
                          ALIGN_W'($urandom()));
            end else if (roll < 80) begin
                if (offered_sizes.size() > 0 && $urandom_range(9) < 7) begin
                    fit = offered_sizes[$urandom_range(offered_sizes.size() - 1)];
                    rsize = fit - SIZE_W'($urandom_range(fit >> (cur_shift + 1)));
                end else begin
                    rsize = draw_size(cur_min);
                end
                send_word(REQ_TAKE, $urandom(), SIZE_W'($urandom()), rsize, draw_align());
            end else if (roll < 96) begin
                send_word(REQ_GIVE, $urandom(), SIZE_W'($urandom()), SIZE_W'($urandom()),
                          ALIGN_W'($urandom()));
            end else begin
                send_word(REQ_UNUSED, $urandom(), SIZE_W'($urandom()), SIZE_W'($urandom()),
                          ALIGN_W'($urandom()));
            end
        end
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] min_b, input logic [SHIFT_W-1:0] shift,
                             input int idle_pct, input int stall_pct, input bit squeeze,
                             input int count);
        settle();
        write_register(CFG_MIN_BLOCK, min_b);
        write_register(CFG_WASTE_SHIFT, SIZE_W'(shift));
        cfg_valid <= 1'b0;
        cur_min = min_b;
        cur_shift = shift;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        if (squeeze)
            hold_asks <= hold_asks + 1;
        send_random_words(count);
    endtask

    initial begin : stimulus
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table, unused request code and refused keeps.
        send_word(REQ_GIVE, '0, '0, '0, '0);
        send_word(REQ_TAKE, '0, '0, 25'd40000, '0);
        send_word(REQ_UNUSED, '1, '1, '1, '1);
        send_word(REQ_KEEP, 32'h0000_4000, MIN_BLOCK_RESET - 1'b1, '0, '0);
        send_word(REQ_KEEP, 32'h0000_4000, '0, '0, '0);
        // Keeps at the size limits, at address zero and with equal sizes.
        send_word(REQ_KEEP, '0, MIN_BLOCK_RESET, '0, '0);
        send_word(REQ_KEEP, '1, SIZE_MAX, '0, '0);
        send_word(REQ_KEEP, 32'h1000_0000, 25'd40000, '0, '0);
        send_word(REQ_KEEP, 32'h0000_1000, 25'd40000, '0, '0);
        send_word(REQ_KEEP, 32'h8000_0000, 25'd50000, '0, '0);
        send_word(REQ_KEEP, 32'h0000_3000, 25'd65536, '0, '0);
        send_word(REQ_KEEP, 32'h0002_0000, 25'd65536, '0, '0);
        // Takes: below minimum, too much waste, tie, full alignment, largest size, minimum size.
        send_word(REQ_TAKE, '0, '0, MIN_BLOCK_RESET - 1'b1, '0);
        send_word(REQ_TAKE, '0, '0, 25'd33000, '0);
        send_word(REQ_TAKE, '0, '0, 25'd38000, '0);
        send_word(REQ_TAKE, '0, '0, 25'd45000, 5'd31);
        send_word(REQ_TAKE, '0, '0, SIZE_MAX, '0);
        send_word(REQ_TAKE, '0, '0, MIN_BLOCK_RESET, 5'd12);
        // Give-backs down to an empty table.
        repeat (4) send_word(REQ_GIVE, '0, '0, '0, '0);

        // Fill the table past its capacity, then give most of it back.
        settle();
        repeat (TABLE_DEPTH + 2)
            send_word(REQ_KEEP, draw_addr(), cur_min + SIZE_W'($urandom_range(cur_min)),
                      SIZE_W'($urandom()), ALIGN_W'($urandom()));
        repeat (60)
            send_word(REQ_GIVE, $urandom(), SIZE_W'($urandom()), SIZE_W'($urandom()),
                      ALIGN_W'($urandom()));

        run_phase(25'd1, 3'd0, 0, 0, 1'b0, 70);
        run_phase(MIN_BLOCK_RESET, WASTE_SHIFT_RESET, 82, 0, 1'b0, 70);
        run_phase(SIZE_MAX, 3'd7, 0, 82, 1'b0, 40);
        run_phase(25'd4096, 3'd7, 21, 21, 1'b0, 70);
        run_phase(25'd1000, 3'd1, 0, 0, 1'b1, 100);
        settle();

        $display("Covered %0d result words (%0d done, %0d refused, missed or empty)",
                 words_done + words_refused, words_done, words_refused);
        $display("under %0d register writes, a full table and a long result stall.",
                 reg_writes);
        if (fail_count == 0 && pending_words == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bbrt_pkg.sv
rtl/bbrt_entry_ram.sv
rtl/big_block_reuse_table.sv
verif/big_block_reuse_table_checker.sv
verif/tb_big_block_reuse_table.sv
